// ===== design/http_chunked_body_decoder_assert.svh =====
// Assertion macros used by the decoder's parser module.
`ifndef HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCBD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HCBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/hcbd_pkg.sv =====
package hcbd_pkg;

   localparam int SIZE_BITS = 64;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;

   localparam logic [16:0] TRAILER_SAT = 17'h1FFFF;
   localparam logic [15:0] LIMIT_RESET = 16'd4096;

   localparam logic CSR_TRAILER_LIMIT = 1'b0;
   localparam logic CSR_LINE_LIMIT    = 1'b1;

   typedef struct packed {
      logic [15:0] trailer_limit;
      logic [15:0] line_limit;
   } hcbd_cfg_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       payload_valid;
      logic       done_flag;
      logic       framing_error;
   } hcbd_result_type;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] value;
   } hcbd_hex_type;

   function automatic hcbd_hex_type hex_decode(input logic [7:0] b);
      hcbd_hex_type h;
      h.is_hex = 1'b1;
      h.value  = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         h.value = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         h.value = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         h.value = 4'(b - 8'h37);
      end else begin
         h.is_hex = 1'b0;
      end
      return h;
   endfunction

endpackage

// ===== design/http_chunked_body_decoder.sv =====
// Chunked HTTP body decoder. One body byte is taken per transfer on the req_ side and exactly
// one result comes out on the rsp_ side for it: the byte itself when it is chunk data, and the
// sticky body_done and framing_error flags. The block sustains one byte per clock cycle while
// rsp_stall does not hold the result register; each byte passes an input register, then the
// parse-state update into the result register, and that update is what sets the rate. Limits are
// written on the csr_ port, index 0 for the trailer limit and 1 for the size line limit, both
// 4096 after reset; write them only while no byte is in flight. After done or an error every
// further byte still yields a result, with the flags held.
module http_chunked_body_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_body_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_payload_valid,
   output logic        rsp_body_done,
   output logic        rsp_framing_error,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wr_data
);
   import hcbd_pkg::*;

   hcbd_cfg_type    cfg_ff, cfg_in;
   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff, in_byte_in;
   logic            out_valid_ff, out_valid_in;
   hcbd_result_type out_ff, out_in;
   hcbd_result_type result;
   logic            out_free;
   logic            advance;
   logic            req_take;

   // The result register is free when empty or being drained this cycle.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TRAILER_LIMIT: cfg_in.trailer_limit = csr_wr_data;
            CSR_LINE_LIMIT:    cfg_in.line_limit    = csr_wr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_body_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_in       = result;
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end
   end

   hcbd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .body_byte (in_byte_ff),
      .cfg       (cfg_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trailer_limit <= LIMIT_RESET;
         cfg_ff.line_limit    <= LIMIT_RESET;
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_payload_byte  = out_ff.payload_byte;
   assign rsp_payload_valid = out_ff.payload_valid;
   assign rsp_body_done     = out_ff.done_flag;
   assign rsp_framing_error = out_ff.framing_error;

endmodule

// ===== design/hcbd_parser.sv =====
`include "http_chunked_body_decoder_assert.svh"

module hcbd_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic [7:0]               body_byte,
   input  hcbd_pkg::hcbd_cfg_type   cfg,
   output hcbd_pkg::hcbd_result_type result
);
   import hcbd_pkg::*;

   localparam logic [3:0] PH_DIGITS   = 4'd0;
   localparam logic [3:0] PH_WS       = 4'd1;
   localparam logic [3:0] PH_SEMI     = 4'd2;
   localparam logic [3:0] PH_EXT      = 4'd3;
   localparam logic [3:0] PH_DATA     = 4'd4;
   localparam logic [3:0] PH_END_CR   = 4'd5;
   localparam logic [3:0] PH_END_LF   = 4'd6;
   localparam logic [3:0] PH_TR_START = 4'd7;
   localparam logic [3:0] PH_TR_LINE  = 4'd8;
   localparam logic [3:0] PH_DONE     = 4'd9;
   localparam logic [3:0] PH_ERR      = 4'd10;

   logic [3:0]           phase_ff, phase_in;
   logic [SIZE_BITS-1:0] chunk_rem_ff, chunk_rem_in;
   logic                 digit_seen_ff, digit_seen_in;
   logic                 pending_cr_ff, pending_cr_in;
   logic [15:0]          line_bytes_ff, line_bytes_in;
   logic [16:0]          trailer_bytes_ff, trailer_bytes_in;

   hcbd_hex_type   hex;
   logic           go_on;
   logic [3:0]     eff_phase;
   logic           is_ws;
   logic           pay;
   logic           ph_err;
   logic           ph_done;
   logic           ph_data;
   logic           ph_suffix;

   assign hex   = hex_decode(body_byte);
   assign is_ws = (body_byte == CHAR_SPACE) || (body_byte == CHAR_TAB);

   always_comb begin
      phase_in         = phase_ff;
      chunk_rem_in     = chunk_rem_ff;
      digit_seen_in    = digit_seen_ff;
      pending_cr_in    = pending_cr_ff;
      line_bytes_in    = line_bytes_ff;
      trailer_bytes_in = trailer_bytes_ff;
      go_on            = 1'b1;
      eff_phase        = phase_ff;
      pay              = 1'b0;
      unique case (phase_ff) inside
         PH_DIGITS, PH_WS, PH_SEMI, PH_EXT: begin
            if (line_bytes_ff >= cfg.line_limit) begin
               phase_in = PH_ERR;
            end else begin
               line_bytes_in = line_bytes_ff + 16'd1;
               if (pending_cr_ff) begin
                  pending_cr_in = 1'b0;
                  if (body_byte == CHAR_LF) begin
                     go_on = 1'b0;
                     if (phase_ff == PH_DIGITS || phase_ff == PH_EXT) begin
                        // End of the size line: on to data, or to trailers.
                        line_bytes_in = 16'd0;
                        digit_seen_in = 1'b0;
                        if (chunk_rem_ff == '0) begin
                           trailer_bytes_in = 17'd0;
                           phase_in         = PH_TR_START;
                        end else begin
                           phase_in = PH_DATA;
                        end
                     end else begin
                        phase_in = PH_ERR;
                     end
                  end else if (phase_ff != PH_SEMI && phase_ff != PH_EXT) begin
                     go_on    = 1'b0;
                     phase_in = PH_ERR;
                  end else begin
                     // A bare CR inside an extension is an ordinary byte.
                     eff_phase = PH_EXT;
                     phase_in  = PH_EXT;
                  end
               end
               if (go_on) begin
                  case (eff_phase)
                     PH_DIGITS: begin
                        if (hex.is_hex) begin
                           if (chunk_rem_ff[SIZE_BITS-1 -: 4] != 4'd0) begin
                              phase_in = PH_ERR;
                           end else begin
                              chunk_rem_in  = {chunk_rem_ff[SIZE_BITS-5:0], hex.value};
                              digit_seen_in = 1'b1;
                           end
                        end else if (!digit_seen_ff) begin
                           phase_in = PH_ERR;
                        end else if (body_byte == CHAR_CR) begin
                           pending_cr_in = 1'b1;
                        end else if (is_ws) begin
                           phase_in = PH_WS;
                        end else if (body_byte == CHAR_SEMI) begin
                           phase_in = PH_SEMI;
                        end else begin
                           phase_in = PH_ERR;
                        end
                     end
                     PH_WS: begin
                        if (body_byte == CHAR_SEMI) begin
                           phase_in = PH_SEMI;
                        end else if (!is_ws) begin
                           phase_in = PH_ERR;
                        end
                     end
                     PH_SEMI: begin
                        if (body_byte == CHAR_CR) begin
                           pending_cr_in = 1'b1;
                        end else begin
                           phase_in = PH_EXT;
                        end
                     end
                     default: begin
                        if (body_byte == CHAR_CR) begin
                           pending_cr_in = 1'b1;
                        end
                     end
                  endcase
               end
            end
         end
         PH_DATA: begin
            pay          = 1'b1;
            chunk_rem_in = chunk_rem_ff - SIZE_BITS'(1);
            if (chunk_rem_ff == SIZE_BITS'(1)) begin
               phase_in = PH_END_CR;
            end
         end
         PH_END_CR: begin
            phase_in = (body_byte == CHAR_CR) ? PH_END_LF : PH_ERR;
         end
         PH_END_LF: begin
            if (body_byte == CHAR_LF) begin
               phase_in      = PH_DIGITS;
               chunk_rem_in  = '0;
               digit_seen_in = 1'b0;
               pending_cr_in = 1'b0;
               line_bytes_in = 16'd0;
            end else begin
               phase_in = PH_ERR;
            end
         end
         PH_TR_START, PH_TR_LINE: begin
            if (trailer_bytes_ff != TRAILER_SAT) begin
               trailer_bytes_in = trailer_bytes_ff + 17'd1;
            end
            if (pending_cr_ff) begin
               pending_cr_in = 1'b0;
               if (body_byte == CHAR_LF) begin
                  go_on = 1'b0;
                  // The limit is checked as each trailer line ends.
                  if (trailer_bytes_in > {1'b0, cfg.trailer_limit}) begin
                     phase_in = PH_ERR;
                  end else if (phase_ff == PH_TR_START) begin
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = PH_TR_START;
                  end
               end else begin
                  phase_in = PH_TR_LINE;
               end
            end
            if (go_on) begin
               if (body_byte == CHAR_CR) begin
                  pending_cr_in = 1'b1;
               end else begin
                  phase_in = PH_TR_LINE;
               end
            end
         end
         PH_DONE: begin
         end
         default: begin
            phase_in = PH_ERR;
         end
      endcase
   end

   assign result.payload_byte  = pay ? body_byte : 8'd0;
   assign result.payload_valid = pay;
   assign result.done_flag     = (phase_in == PH_DONE);
   assign result.framing_error = (phase_in == PH_ERR);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_DIGITS;
         chunk_rem_ff     <= '0;
         digit_seen_ff    <= 1'b0;
         pending_cr_ff    <= 1'b0;
         line_bytes_ff    <= 16'd0;
         trailer_bytes_ff <= 17'd0;
      end else if (advance) begin
         phase_ff         <= phase_in;
         chunk_rem_ff     <= chunk_rem_in;
         digit_seen_ff    <= digit_seen_in;
         pending_cr_ff    <= pending_cr_in;
         line_bytes_ff    <= line_bytes_in;
         trailer_bytes_ff <= trailer_bytes_in;
      end
   end

   assign ph_err    = (phase_ff == PH_ERR);
   assign ph_done   = (phase_ff == PH_DONE);
   assign ph_data   = (phase_ff == PH_DATA);
   assign ph_suffix = (phase_ff == PH_WS) || (phase_ff == PH_SEMI) || (phase_ff == PH_EXT);

   `HCBD_ASSERT_NEXT(a_err_sticky, clock, reset, ph_err, ph_err, "error phase left")
   `HCBD_ASSERT_NEXT(a_done_sticky, clock, reset, ph_done, ph_done, "done phase left")
   `HCBD_ASSERT_NOW(a_data_nonzero, clock, reset, ph_data, chunk_rem_ff != '0, "empty data phase")
   `HCBD_ASSERT_NOW(a_ext_has_digit, clock, reset, ph_suffix, digit_seen_ff, "suffix, no digit")

endmodule
